@@ rtl/core/incremental_grid_component_max_macros.svh @@
// ----------------------------------------------------------------------------
// incremental_grid_component_max_macros
// Assertion macros used by incremental_grid_component_max.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_GRID_COMPONENT_MAX_MACROS_SVH
`define INCREMENTAL_GRID_COMPONENT_MAX_MACROS_SVH

// clocked check, off while reset is asserted
`define IGCM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("igcm check failed");

// condition that must never hold
`define IGCM_NEVER(lbl, cond) \
	`IGCM_ASSERT(lbl, !(cond))

`endif

@@ rtl/core/igcm_pkg.sv @@
// ----------------------------------------------------------------------------
// igcm_pkg
// Shared types and constants of the grid component tracker.
// ----------------------------------------------------------------------------
package igcm_pkg;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_CELL,
		S_NB,
		S_WALK
	} state_t;

	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_ADD   = 1'b1;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam int NB_COUNT = 8;

	typedef logic signed [1:0] offs_t;

	// row offset of neighbor k, scan order row major skipping the center
	function automatic offs_t nb_dr(input logic [2:0] k);
		offs_t r;
		case (k)
			3'd0, 3'd1, 3'd2: r = -2'sd1;
			3'd3, 3'd4:       r = 2'sd0;
			default:          r = 2'sd1;
		endcase
		return r;
	endfunction

	function automatic offs_t nb_dc(input logic [2:0] k);
		offs_t r;
		case (k)
			3'd0, 3'd3, 3'd5: r = -2'sd1;
			3'd1, 3'd6:       r = 2'sd0;
			default:          r = 2'sd1;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/igcm_ram.sv @@
// ----------------------------------------------------------------------------
// igcm_ram
// Simple dual port ram, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module igcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/incremental_grid_component_max.sv @@
// ----------------------------------------------------------------------------
// incremental_grid_component_max
// Union-find tracker of 8-connected components on a grid of set cells,
// reporting the largest component size after every request.
// ----------------------------------------------------------------------------
// channel   signals                          handshake
// request   op, row, col                     start & !busy
// result    largest_size, range_error        done, one cycle, no stall
// config    cfg_we, cfg_index, cfg_data      cfg_we, immediate
//
// add: busy while the cell is read and set, each grid neighbor is read and
//   each set neighbor's root chain followed (short under union by size)
// add of a set cell: busy only in S_CELL; add outside the grid: never busy
// clear: busy while all ram words are cleared, one ram word per cycle
// after reset a clearing pass over all ram words holds busy high
// results come as busy falls (off-grid add: after start), cannot be held off
// ----------------------------------------------------------------------------
`include "incremental_grid_component_max_macros.svh"

module incremental_grid_component_max #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	output logic        done,
	output logic [12:0] largest_size,
	output logic        range_error,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int CW    = $clog2(CELLS);
	localparam int SW    = $clog2(CELLS + 1);
	localparam int DW    = 1 + CW + SW;
	localparam int RRW   = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
	localparam int RCW   = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;

	igcm_pkg::state_t state_q, state_d;

	logic [6:0]    rows_q, cols_q;
	logic [RRW-1:0] rows_eff;
	logic [RCW-1:0] cols_eff;
	logic [5:0]    row_q, col_q;
	logic [CW-1:0] cell_q, cur_root_q, x_q, clr_cnt_q;
	logic [SW-1:0] cur_size_q, largest_q;
	logic [3:0]    k_q;
	logic          first_q;
	logic          done_q, err_q;

	logic          we;
	logic [CW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;
	logic          r_occ;
	logic [CW-1:0] r_par;
	logic [SW-1:0] r_size;

	logic signed [7:0] nr, nc;
	logic          nb_ok;
	logic [CW-1:0] nb_idx, add_idx;
	logic          add_err;

	assign r_occ  = rdata[DW-1];
	assign r_par  = rdata[CW+SW-1:SW];
	assign r_size = rdata[SW-1:0];

	assign rows_eff = (RRW'(rows_q) > RRW'(MAX_ROWS)) ? RRW'(MAX_ROWS) : RRW'(rows_q);
	assign cols_eff = (RCW'(cols_q) > RCW'(MAX_COLS)) ? RCW'(MAX_COLS) : RCW'(cols_q);

	assign add_err = (RRW'(row) >= rows_eff) || (RCW'(col) >= cols_eff);
	assign add_idx = CW'(row) * CW'(MAX_COLS) + CW'(col);

	assign nr = $signed({2'b00, row_q}) + 8'(igcm_pkg::nb_dr(k_q[2:0]));
	assign nc = $signed({2'b00, col_q}) + 8'(igcm_pkg::nb_dc(k_q[2:0]));
	assign nb_ok = (nr >= 8'sd0) && (nc >= 8'sd0)
		&& (RRW'(nr[6:0]) < rows_eff) && (RCW'(nc[6:0]) < cols_eff);
	assign nb_idx = CW'(nr[6:0]) * CW'(MAX_COLS) + CW'(nc[6:0]);

	igcm_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// next state and ram port
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		raddr   = '0;
		case (state_q)
			igcm_pkg::S_CLR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
				if (clr_cnt_q == CW'(CELLS - 1)) begin
					state_d = igcm_pkg::S_IDLE;
				end
			end
			igcm_pkg::S_IDLE: begin
				raddr = add_idx;
				if (start) begin
					if (op == igcm_pkg::OP_CLEAR) begin
						state_d = igcm_pkg::S_CLR;
					end else if (!add_err) begin
						state_d = igcm_pkg::S_CELL;
					end
				end
			end
			igcm_pkg::S_CELL: begin
				if (r_occ) begin
					state_d = igcm_pkg::S_IDLE;
				end else begin
					we      = 1'b1;
					waddr   = cell_q;
					wdata   = {1'b1, cell_q, SW'(1)};
					state_d = igcm_pkg::S_NB;
				end
			end
			igcm_pkg::S_NB: begin
				if (k_q == 4'(igcm_pkg::NB_COUNT)) begin
					// settle the root word of the grown set
					we      = 1'b1;
					waddr   = cur_root_q;
					wdata   = {1'b1, cur_root_q, cur_size_q};
					state_d = igcm_pkg::S_IDLE;
				end else if (nb_ok) begin
					raddr   = nb_idx;
					state_d = igcm_pkg::S_WALK;
				end
			end
			igcm_pkg::S_WALK: begin
				if ((first_q && !r_occ) || x_q == cur_root_q) begin
					state_d = igcm_pkg::S_NB;
				end else if (r_par == x_q) begin
					// other root found: link smaller under larger
					we      = 1'b1;
					state_d = igcm_pkg::S_NB;
					if (cur_size_q >= r_size) begin
						waddr = x_q;
						wdata = {1'b1, cur_root_q, r_size};
					end else begin
						waddr = cur_root_q;
						wdata = {1'b1, x_q, cur_size_q};
					end
				end else begin
					raddr = r_par;
				end
			end
			default: state_d = igcm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= igcm_pkg::S_CLR;
			clr_cnt_q <= '0;
			largest_q <= '0;
			done_q    <= 1'b0;
			err_q     <= 1'b0;
			rows_q    <= 7'd64;
			cols_q    <= 7'd64;
			k_q       <= '0;
			first_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we && cfg_index[1] == 1'b0) begin
				if (cfg_index[0] == igcm_pkg::REG_ROWS) begin
					rows_q <= cfg_data;
				end else begin
					cols_q <= cfg_data;
				end
			end
			case (state_q)
				igcm_pkg::S_CLR: begin
					clr_cnt_q <= clr_cnt_q + CW'(1);
					if (clr_cnt_q == CW'(CELLS - 1)) begin
						clr_cnt_q <= '0;
						done_q    <= first_q;
						err_q     <= 1'b0;
						largest_q <= '0;
					end
				end
				igcm_pkg::S_IDLE: begin
					if (start) begin
						row_q  <= row;
						col_q  <= col;
						cell_q <= add_idx;
						if (op == igcm_pkg::OP_CLEAR) begin
							// marks the sweep as one that answers a request
							first_q <= 1'b1;
						end else if (add_err) begin
							done_q <= 1'b1;
							err_q  <= 1'b1;
						end
					end
				end
				igcm_pkg::S_CELL: begin
					if (r_occ) begin
						done_q <= 1'b1;
						err_q  <= 1'b0;
					end
					cur_root_q <= cell_q;
					cur_size_q <= SW'(1);
					k_q        <= '0;
				end
				igcm_pkg::S_NB: begin
					if (k_q == 4'(igcm_pkg::NB_COUNT)) begin
						done_q <= 1'b1;
						err_q  <= 1'b0;
						if (cur_size_q > largest_q) begin
							largest_q <= cur_size_q;
						end
					end else if (nb_ok) begin
						x_q     <= nb_idx;
						first_q <= 1'b1;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				igcm_pkg::S_WALK: begin
					first_q <= 1'b0;
					if ((first_q && !r_occ) || x_q == cur_root_q) begin
						k_q <= k_q + 4'd1;
					end else if (r_par == x_q) begin
						k_q        <= k_q + 4'd1;
						cur_size_q <= cur_size_q + r_size;
						if (cur_size_q < r_size) begin
							cur_root_q <= x_q;
						end
					end else begin
						x_q <= r_par;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy         = (state_q != igcm_pkg::S_IDLE);
	assign done         = done_q;
	assign range_error  = err_q;
	assign largest_size = 13'(largest_q);

	`IGCM_ASSERT(a_done_after_work, (done_q && !err_q) |-> $past(busy))
	`IGCM_NEVER(a_no_done_in_sweep, (state_q == igcm_pkg::S_CLR) && done_q)
	`IGCM_ASSERT(a_size_bounded, (state_q == igcm_pkg::S_WALK) |-> (cur_size_q <= SW'(CELLS)))
	`IGCM_ASSERT(a_err_keeps_largest, (done_q && err_q) |-> $stable(largest_q))

endmodule
